### src/rf_pulse_code_transmitter_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pulse code transmitter
// Clocked on clk_i, disabled while rst_ni is low. Empty when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef RF_PULSE_CODE_TRANSMITTER_CORE_ASSERT_SVH
`define RF_PULSE_CODE_TRANSMITTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define RPCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rpct assertion failed");

// expression must never be true outside reset
`define RPCT_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("rpct forbidden condition seen");

`else

`define RPCT_ASSERT(lbl, prop)
`define RPCT_ASSERT_NEVER(lbl, expr)

`endif

`endif

### src/rpct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpct_pkg
// Shared constants, types and the phase length lookup.
// ---------------------------------------------------------------------------
package rpct_pkg;

  localparam int CODE_MAX_BITS = 64;
  localparam int CODE_W        = 64;
  localparam int LEN_W         = 7;
  localparam int CNT_W         = 8;
  localparam int IDX_W         = 8;
  localparam int BIT_SEL_W     = $clog2(CODE_W);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_FIRST  = 3'd0,
    REG_SYNC_SECOND = 3'd1,
    REG_ZERO_FIRST  = 3'd2,
    REG_ZERO_SECOND = 3'd3,
    REG_ONE_FIRST   = 3'd4,
    REG_ONE_SECOND  = 3'd5,
    REG_INV_POL     = 3'd6,
    REG_REPEATS     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0] sync_first;
    logic [CNT_W-1:0] sync_second;
    logic [CNT_W-1:0] zero_first;
    logic [CNT_W-1:0] zero_second;
    logic [CNT_W-1:0] one_first;
    logic [CNT_W-1:0] one_second;
    logic             inverted;
    logic [CNT_W-1:0] frame_repeats;
  } cfg_t;

  typedef struct packed {
    logic enable;
    logic level;
    logic busy;
    logic done;
  } res_t;

  // length of the current phase in ticks; zero counts as one
  function automatic logic [CNT_W-1:0] phase_len(cfg_t cfg, logic is_sync, logic bit_one,
                                                 logic second);
    logic [CNT_W-1:0] len;
    if (is_sync) begin
      len = second ? cfg.sync_second : cfg.sync_first;
    end else if (bit_one) begin
      len = second ? cfg.one_second : cfg.one_first;
    end else begin
      len = second ? cfg.zero_second : cfg.zero_first;
    end
    return (len == '0) ? CNT_W'(1) : len;
  endfunction

endpackage
`default_nettype wire

### src/rf_pulse_code_transmitter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rf_pulse_code_transmitter_core
// OOK pulse-width code sender: sync plus code symbols, repeated per start.
// ---------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  func_i, code_bits_i, code_length_i
// out      output     out_valid_o/out_stall_i radio_enable_o, radio_level_o,
//                                            busy_res_o, done_res_o
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i does not hold the result register.
// Item path: input register -> sequencer step -> result register.
// Every item (start or tick) gives exactly one result, the outputs after it.
// A full result register under out_stall_i holds the input register too.
// Reset clears all control state and loads the register defaults; no sweep.
// ---------------------------------------------------------------------------
module rf_pulse_code_transmitter_core
  import rpct_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // start/tick items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [CODE_W-1:0]     code_bits_i,
  input  logic [LEN_W-1:0]      code_length_i,
  // results
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  radio_enable_o,
  output logic                  radio_level_o,
  output logic                  busy_res_o,
  output logic                  done_res_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // input register
  logic              in_vld_q, in_vld_d;
  logic              in_func_q;
  logic [CODE_W-1:0] in_bits_q;
  logic [LEN_W-1:0]  in_len_q;

  // result register
  logic out_vld_q, out_vld_d;
  res_t res_q;
  res_t res_next;

  cfg_t cfg;
  logic adv;      // sequencer step this cycle
  logic in_xfer;  // input transfer this cycle
  logic cfg_wr;

  // step whenever the result register is free or being drained
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_xfer || (in_vld_q && !adv);
  assign out_vld_d  = adv || (out_vld_q && out_stall_i);
  assign cfg_wr     = cfg_valid_i && cfg_ready_o;

  rpct_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_wr),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rpct_sequencer u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (adv),
    .func_i        (in_func_q),
    .code_bits_i   (in_bits_q),
    .code_length_i (in_len_q),
    .cfg_i         (cfg),
    .res_o         (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_func_q <= func_i;
      in_bits_q <= code_bits_i;
      in_len_q  <= code_length_i;
    end
    if (adv) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign radio_enable_o = res_q.enable;
  assign radio_level_o  = res_q.level;
  assign busy_res_o     = res_q.busy;
  assign done_res_o     = res_q.done;

endmodule
`default_nettype wire

### src/rpct_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpct_cfg_regs
// Configuration register file; always ready, one write per transfer.
// ---------------------------------------------------------------------------
module rpct_cfg_regs
  import rpct_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_SYNC_FIRST:  cfg_d.sync_first    = cfg_data_i;
        REG_SYNC_SECOND: cfg_d.sync_second   = cfg_data_i;
        REG_ZERO_FIRST:  cfg_d.zero_first    = cfg_data_i;
        REG_ZERO_SECOND: cfg_d.zero_second   = cfg_data_i;
        REG_ONE_FIRST:   cfg_d.one_first     = cfg_data_i;
        REG_ONE_SECOND:  cfg_d.one_second    = cfg_data_i;
        REG_INV_POL:     cfg_d.inverted      = cfg_data_i[0];
        REG_REPEATS:     cfg_d.frame_repeats = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first    <= CNT_W'(1);
      cfg_q.sync_second   <= CNT_W'(31);
      cfg_q.zero_first    <= CNT_W'(1);
      cfg_q.zero_second   <= CNT_W'(3);
      cfg_q.one_first     <= CNT_W'(3);
      cfg_q.one_second    <= CNT_W'(1);
      cfg_q.inverted      <= 1'b0;
      cfg_q.frame_repeats <= CNT_W'(10);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

### src/rpct_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpct_sequencer
// Frame/symbol/phase state and its one-step update per start or tick.
// ---------------------------------------------------------------------------
`include "rf_pulse_code_transmitter_core_assert.svh"
module rpct_sequencer
  import rpct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              func_i,
  input  logic [CODE_W-1:0] code_bits_i,
  input  logic [LEN_W-1:0]  code_length_i,
  input  cfg_t              cfg_i,
  output res_t              res_o
);

  logic             active_q, active_d;
  logic             enable_q, enable_d;
  logic             level_q, level_d;
  logic [CNT_W-1:0] phase_count_q, phase_count_d;
  logic [IDX_W-1:0] phase_index_q, phase_index_d;
  logic [CNT_W-1:0] repeat_count_q, repeat_count_d;
  logic [LEN_W-1:0] code_count_q, code_count_d;
  logic [CODE_W-1:0] code_store_q;
  logic             load;
  logic             done;

  logic [IDX_W-2:0]     sym;
  logic [BIT_SEL_W-1:0] bit_sel;
  logic [CNT_W-1:0]     len;
  logic [CNT_W-1:0]     cnt_inc;
  logic [IDX_W-1:0]     idx_inc;
  logic [CNT_W-1:0]     rep_inc;
  logic [LEN_W-1:0]     len_sat;
  logic                 hit, frame_end, last;

  // symbol 0 is sync, symbol s carries code bit s-1
  assign sym     = phase_index_q[IDX_W-1:1];
  assign bit_sel = BIT_SEL_W'(sym - 1'b1);
  assign len     = phase_len(cfg_i, sym == '0, code_store_q[bit_sel], phase_index_q[0]);
  assign cnt_inc = phase_count_q + 1'b1;
  assign idx_inc = phase_index_q + 1'b1;
  assign rep_inc = repeat_count_q + 1'b1;
  assign hit       = cnt_inc >= len;
  assign frame_end = !idx_inc[0] && (idx_inc[IDX_W-1:1] > code_count_q);
  assign last      = rep_inc >= cfg_i.frame_repeats;
  assign len_sat   = (code_length_i > LEN_W'(CODE_MAX_BITS)) ? LEN_W'(CODE_MAX_BITS)
                                                             : code_length_i;

  always_comb begin
    active_d       = active_q;
    enable_d       = enable_q;
    level_d        = level_q;
    phase_count_d  = phase_count_q;
    phase_index_d  = phase_index_q;
    repeat_count_d = repeat_count_q;
    code_count_d   = code_count_q;
    load           = 1'b0;
    done           = 1'b0;
    if (step_i) begin
      if (func_i == FUNC_START) begin
        if (!active_q) begin
          load           = 1'b1;
          code_count_d   = len_sat;
          repeat_count_d = '0;
          active_d       = 1'b1;
          enable_d       = 1'b1;
          phase_index_d  = '0;
          phase_count_d  = '0;
          level_d        = !cfg_i.inverted;
        end
      end else if (active_q) begin
        phase_count_d = cnt_inc;
        if (hit) begin
          level_d       = !level_q;
          phase_count_d = '0;
          phase_index_d = idx_inc;
          if (frame_end) begin
            repeat_count_d = rep_inc;
            if (last) begin
              active_d = 1'b0;
              enable_d = 1'b0;
              done     = 1'b1;
            end else begin
              phase_index_d = '0;
              phase_count_d = '0;
              level_d       = !cfg_i.inverted;
            end
          end
        end
      end
    end
  end

  assign res_o.enable = enable_d;
  assign res_o.level  = level_d;
  assign res_o.busy   = active_d;
  assign res_o.done   = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= 1'b0;
      enable_q       <= 1'b0;
      level_q        <= 1'b0;
      phase_count_q  <= '0;
      phase_index_q  <= '0;
      repeat_count_q <= '0;
      code_count_q   <= '0;
    end else begin
      active_q       <= active_d;
      enable_q       <= enable_d;
      level_q        <= level_d;
      phase_count_q  <= phase_count_d;
      phase_index_q  <= phase_index_d;
      repeat_count_q <= repeat_count_d;
      code_count_q   <= code_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_store_q <= code_bits_i;
    end
  end

  `RPCT_ASSERT_NEVER(a_enable_tracks_active, active_q != enable_q)
  `RPCT_ASSERT_NEVER(a_sym_in_frame, active_q && (sym > code_count_q))
  `RPCT_ASSERT_NEVER(a_code_count_sat, code_count_q > LEN_W'(CODE_MAX_BITS))
  `RPCT_ASSERT(a_done_drops_active, done |=> !active_q)

endmodule
`default_nettype wire
